@@ rtl/mbb_pkg.sv @@
`default_nettype none

package mbb_pkg;

   // Opcodes of the request beat
   localparam logic [2:0] OP_WRITE  = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_LOAD   = 3'd2;
   localparam logic [2:0] OP_REWIND = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam int STORE_BYTES_DEFAULT = 4096;
   localparam logic [4:0] MAX_FIELD_BITS = 5'd25;

   // Index arithmetic width: covers a 13-bit cursor plus offsets and stores up to 64 KiB
   localparam int IDX_W = 18;

   localparam logic [12:0] SIZE_RESET = 13'd4096;

   typedef struct packed {
      logic [2:0]  op;
      logic [24:0] bits_value;
      logic [4:0]  bit_count;
      logic [11:0] byte_addr;
   } req_type;

   typedef struct packed {
      logic [24:0] read_value;
      logic        ok;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/msb_first_bit_buffer_unit.sv @@
`default_nettype none

// MSB-first bit buffer: a byte store with one bit cursor.
// Request channel (req_valid/req_stall/req_data) carries one command per beat:
// write bits, read bits, load byte, rewind, or clear and rewind. Every request beat
// produces exactly one response beat (rsp_valid/rsp_stall/rsp_data) with the read
// field (right aligned) and an ok flag.
// csr_wr_en/csr_wr_data set the number of store bytes in use; write it only while idle.
// A write or read touches nb = ceil((bit_cursor+bit_count)/8) bytes (0 to 4) through
// the single byte-wide store port, one byte per cycle, pipelined behind the registered
// read, and then waits in the finish state for the response register. Load byte,
// rewind, unknown ops and refused accesses go straight to the finish state; clear
// sweeps every byte of the store, one byte at a time, before it goes to the finish state.
// One command is in flight at a time; the next request can be taken in the cycle the
// response is presented, even while the response register is still stalled.
// Reset: the store is cleared by a sweep of every byte, during which req_stall
// stays high; csr writes are taken throughout. Cursor and size return to reset values.
// A stalled response holds its payload; a finished command waits for the register.
module msb_first_bit_buffer_unit
   import mbb_pkg::*;
#(
   parameter int STORE_BYTES = STORE_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [12:0] csr_wr_data
);

   localparam int AW = $clog2(STORE_BYTES);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_RMW    = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [12:0]   size_ff, size_in;
   logic [12:0]   byte_cur_ff, byte_cur_in;
   logic [2:0]    bit_cur_ff, bit_cur_in;
   logic [12:0]   base_ff, base_in;
   logic          is_read_ff, is_read_in;
   logic          ok_ff, ok_in;
   logic [4:0]    count_ff, count_in;
   logic [5:0]    sh_ff, sh_in;
   logic [2:0]    nb_ff, nb_in;
   logic [2:0]    iss_k_ff, iss_k_in;
   logic          pend_ff, pend_in;
   logic [1:0]    pk_ff, pk_in;
   logic [31:0]   win_ff, win_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [7:0]    store_mem [STORE_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] mem_ra;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;

   logic          req_accept;
   logic          rsp_free;
   logic [5:0]    pos;
   logic [5:0]    pos_up;
   logic [IDX_W-1:0] size_eff;
   logic [IDX_W-1:0] end_idx;
   logic          count_ok;
   logic          fits;
   logic [31:0]   mask;
   logic [31:0]   wr_win;
   logic [31:0]   rd_field;
   logic [IDX_W-1:0] iss_idx;
   logic [IDX_W-1:0] pend_idx;
   logic [IDX_W-1:0] load_idx;
   logic          load_in_range;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Overflow check and field geometry, from the live cursor
   assign pos      = {3'b000, bit_cur_ff} + {1'b0, req_data.bit_count};
   assign pos_up   = pos + 6'd7;
   assign size_eff = (IDX_W'(size_ff) > IDX_W'(STORE_BYTES)) ? IDX_W'(STORE_BYTES)
                                                              : IDX_W'(size_ff);
   assign end_idx  = IDX_W'(byte_cur_ff) + IDX_W'(pos[5:3]);
   assign count_ok = (req_data.bit_count <= MAX_FIELD_BITS);
   assign fits     = count_ok && (end_idx < size_eff);
   assign mask     = 32'((33'd1 << req_data.bit_count) - 33'd1);
   assign wr_win   = (32'(req_data.bits_value) & mask) << (6'd32 - pos);

   assign load_idx      = IDX_W'(req_data.byte_addr);
   assign load_in_range = load_idx < IDX_W'(STORE_BYTES);

   assign iss_idx  = IDX_W'(base_ff) + IDX_W'(iss_k_ff);
   assign pend_idx = IDX_W'(base_ff) + IDX_W'(pk_ff);

   // Right-align the read window; a shift of 32 only occurs with a zero count
   assign rd_field = (win_ff >> sh_ff) & 32'((33'd1 << count_ff) - 33'd1);

   // Store ports: one read, one write per cycle
   always_comb begin
      mem_ra = iss_idx[AW-1:0];
      mem_we = 1'b0;
      mem_wa = pend_idx[AW-1:0];
      mem_wd = rd_data_ff | win_ff[{~pk_ff, 3'b000} +: 8];
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = 8'h00;
         end
         S_IDLE: begin
            mem_we = req_accept && (req_data.op == OP_LOAD) && load_in_range;
            mem_wa = load_idx[AW-1:0];
            mem_wd = req_data.bits_value[7:0];
         end
         S_RMW: begin
            mem_we = pend_ff && !is_read_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= store_mem[mem_ra];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      size_in      = csr_wr_en ? csr_wr_data : size_ff;
      byte_cur_in  = byte_cur_ff;
      bit_cur_in   = bit_cur_ff;
      base_in      = base_ff;
      is_read_in   = is_read_ff;
      ok_in        = ok_ff;
      count_in     = count_ff;
      sh_in        = sh_ff;
      nb_in        = nb_ff;
      iss_k_in     = iss_k_ff;
      pend_in      = 1'b0;
      pk_in        = pk_ff;
      win_in       = win_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(STORE_BYTES - 1)) begin
               clr_in   = '0;
               state_in = clr_rsp_ff ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               // Default: no bytes to touch, go straight to the finish state
               base_in    = byte_cur_ff;
               is_read_in = 1'b0;
               ok_in      = 1'b0;
               count_in   = '0;
               sh_in      = '0;
               nb_in      = '0;
               iss_k_in   = '0;
               win_in     = '0;
               state_in   = S_FINISH;
               case (req_data.op)
                  OP_WRITE, OP_READ: begin
                     is_read_in = (req_data.op == OP_READ);
                     if (fits) begin
                        ok_in       = 1'b1;
                        count_in    = req_data.bit_count;
                        sh_in       = 6'd32 - pos;
                        nb_in       = pos_up[5:3];
                        win_in      = (req_data.op == OP_READ) ? 32'd0 : wr_win;
                        byte_cur_in = byte_cur_ff + 13'(pos[5:3]);
                        bit_cur_in  = pos[2:0];
                        state_in    = S_RMW;
                     end
                  end
                  OP_LOAD: begin
                     ok_in = load_in_range;
                  end
                  OP_REWIND: begin
                     ok_in       = 1'b1;
                     byte_cur_in = '0;
                     bit_cur_in  = '0;
                  end
                  OP_CLEAR: begin
                     ok_in       = 1'b1;
                     byte_cur_in = '0;
                     bit_cur_in  = '0;
                     clr_in      = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_RMW: begin
            // Issue one byte fetch per cycle; merge it in the cycle after
            if (iss_k_ff < nb_ff) begin
               pend_in  = 1'b1;
               pk_in    = iss_k_ff[1:0];
               iss_k_in = iss_k_ff + 3'd1;
            end
            if (pend_ff && is_read_ff) begin
               win_in = win_ff | ({24'd0, rd_data_ff} << {~pk_ff, 3'b000});
            end
            if ((iss_k_ff == nb_ff) && !pend_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Hold until the response register frees up
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = ok_ff;
               rsp_in.read_value  = (is_read_ff && ok_ff) ? rd_field[24:0] : 25'd0;
               clr_rsp_in         = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         size_ff      <= SIZE_RESET;
         byte_cur_ff  <= '0;
         bit_cur_ff   <= '0;
         iss_k_ff     <= '0;
         nb_ff        <= '0;
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         byte_cur_ff  <= byte_cur_in;
         bit_cur_ff   <= bit_cur_in;
         iss_k_ff     <= iss_k_in;
         nb_ff        <= nb_in;
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      is_read_ff <= is_read_in;
      ok_ff      <= ok_in;
      count_ff   <= count_in;
      sh_ff      <= sh_in;
      pk_ff      <= pk_in;
      win_ff     <= win_in;
      rsp_ff     <= rsp_in;
   end

   // A command never leaves the sequencer idle on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after accepting a command");

   // A refused bit access leaves the cursor untouched
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.op == OP_WRITE || req_data.op == OP_READ) && !fits)
      |=> ($stable(byte_cur_ff) && $stable(bit_cur_ff)))
      else $error("cursor moved on a refused access");

   // A field never spans more than four bytes, and issue never runs past it
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW) |-> ((nb_ff <= 3'd4) && (iss_k_ff <= nb_ff)))
      else $error("byte issue count out of range");

   // A merge is only pending while the read-modify-write loop runs
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_RMW))
      else $error("byte merge pending outside the access loop");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mbb_pkg::*;

   // Opcodes the block does not define; each must answer a refusal and change nothing
   localparam logic [2:0] OP_RSVD_A = 3'd5;
   localparam logic [2:0] OP_RSVD_B = 3'd6;
   localparam logic [2:0] OP_RSVD_C = 3'd7;

   localparam int STORE_SIZE   = STORE_BYTES_DEFAULT;
   localparam int IDLE_PCT     = 32;     // chance of an idle cycle on either side
   localparam int PHASE_ITEMS  = 150;    // random commands per store size
   localparam int QUIET_LIMIT  = 20000;  // covers the reset sweep and a clear sweep
   localparam int DRAIN_CYCLES = 16;

   // Store sizes visited after the directed part; the run starts at the reset size
   localparam logic [12:0] SIZE_PLAN [8] = '{13'd1, 13'd0, 13'd37, 13'd8191,
                                             13'd2, 13'd4096, 13'd5, 13'd300};
   localparam int CALM_PHASE = 5;        // no idling on either side in this phase

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [12:0] csr_wr_data = '0;

   // Shadow of the block: byte store, cursor and the size register
   logic [7:0]  store_img [STORE_SIZE];
   int unsigned byte_pos;
   int unsigned bit_pos;
   logic [12:0] size_reg;

   req_type     cmd_q [$];     // commands waiting to be driven
   rsp_type     answer_q [$];  // responses owed by the block, oldest first

   bit          calm       = 1'b0;
   int          errors     = 0;
   int          posted     = 0;
   int          sent       = 0;
   int          checked    = 0;
   int          refused    = 0;
   int          quiet      = 0;

   msb_first_bit_buffer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one command to the shadow and return the response it must produce.
   function automatic rsp_type run_command(input req_type cmd);
      rsp_type     ans;
      int unsigned lim;
      int unsigned cnt;
      int unsigned sh;
      int unsigned idx;
      logic [63:0] mask;
      logic [63:0] win;
      ans = '0;
      cnt = cmd.bit_count;
      // sizes above the store act as the full store
      lim = (size_reg > STORE_SIZE) ? STORE_SIZE : size_reg;
      case (cmd.op)
         OP_WRITE, OP_READ: begin
            // refuse oversize fields and any field reaching the end of the used bytes
            if (cnt <= MAX_FIELD_BITS && ((bit_pos + cnt) >> 3) + byte_pos < lim) begin
               mask = (64'd1 << cnt) - 64'd1;
               sh   = 32 - bit_pos - cnt;
               if (cmd.op == OP_WRITE) begin
                  // OR the field into a 32-bit window starting at the cursor byte
                  win = (64'(cmd.bits_value) & mask) << sh;
                  for (int k = 0; k < 4; k++) begin
                     idx = byte_pos + k;
                     if (idx < STORE_SIZE)
                        store_img[idx] = store_img[idx] | win[31 - 8 * k -: 8];
                  end
               end else begin
                  // bytes past the store read as zero
                  win = '0;
                  for (int k = 0; k < 4; k++) begin
                     idx = byte_pos + k;
                     win = (win << 8) | ((idx < STORE_SIZE) ? 64'(store_img[idx]) : 64'd0);
                  end
                  ans.read_value = 25'((win >> sh) & mask);
               end
               idx      = bit_pos + cnt;
               byte_pos = (byte_pos + (idx >> 3)) & 'h1FFF;
               bit_pos  = idx & 7;
               ans.ok   = 1'b1;
            end
         end
         OP_LOAD: begin
            // load leaves the cursor alone and ignores the size in use
            if (cmd.byte_addr < STORE_SIZE) begin
               store_img[cmd.byte_addr] = cmd.bits_value[7:0];
               ans.ok = 1'b1;
            end
         end
         OP_REWIND: begin
            byte_pos = 0;
            bit_pos  = 0;
            ans.ok   = 1'b1;
         end
         OP_CLEAR: begin
            foreach (store_img[i]) store_img[i] = 8'h00;
            byte_pos = 0;
            bit_pos  = 0;
            ans.ok   = 1'b1;
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic void post(input logic [2:0] op, input logic [24:0] val,
                                input logic [4:0] cnt, input logic [11:0] addr);
      req_type cmd;
      cmd.op         = op;
      cmd.bits_value = val;
      cmd.bit_count  = cnt;
      cmd.byte_addr  = addr;
      cmd_q.push_back(cmd);
      posted++;
   endfunction

   function automatic logic [24:0] rand_val();
      return 25'($urandom);
   endfunction

   function automatic logic [11:0] rand_addr();
      return 12'($urandom);
   endfunction

   // Extremes of every field, every opcode and the refusal cases at the full size
   task automatic post_directed();
      post(OP_CLEAR,  25'h0000000, 5'd0,  12'h000);
      post(OP_WRITE,  25'h1FFFFFF, 5'd25, 12'hFFF);
      post(OP_WRITE,  25'h1FFFFFF, 5'd0,  12'h000);
      post(OP_WRITE,  25'h1FFFFFF, 5'd26, 12'h000);
      post(OP_WRITE,  25'h0AAAAAA, 5'd31, 12'h000);
      post(OP_WRITE,  25'h0000000, 5'd1,  12'h000);
      post(OP_WRITE,  25'h1555555, 5'd7,  12'h000);
      post(OP_LOAD,   25'h1FFFFA5, 5'd31, 12'h000);
      post(OP_LOAD,   25'h00000FF, 5'd0,  12'hFFF);
      post(OP_REWIND, 25'h1FFFFFF, 5'd31, 12'hFFF);
      post(OP_READ,   25'h1FFFFFF, 5'd25, 12'hFFF);
      post(OP_READ,   25'h0000000, 5'd0,  12'h000);
      post(OP_READ,   25'h0000000, 5'd8,  12'h000);
      post(OP_READ,   25'h0000000, 5'd31, 12'h000);
      post(OP_READ,   25'h0000000, 5'd26, 12'h000);
      post(OP_RSVD_A, 25'h1FFFFFF, 5'd25, 12'hFFF);
      post(OP_RSVD_B, 25'h1FFFFFF, 5'd31, 12'h000);
      post(OP_RSVD_C, 25'h0000000, 5'd0,  12'hFFF);
      post(OP_REWIND, 25'h0000000, 5'd0,  12'h000);
      post(OP_READ,   25'h0000000, 5'd25, 12'h000);
      post(OP_READ,   25'h0000000, 5'd25, 12'h000);
      post(OP_CLEAR,  25'h1FFFFFF, 5'd31, 12'hFFF);
      post(OP_READ,   25'h0000000, 5'd25, 12'h000);
   endtask

   // Write a run of fields behind a random lead-in, rewind and read them back.
   // Zero the touched bytes first so the read-back shows each field intact.
   task automatic post_round_trip();
      int         n;
      int         lead;
      int         total;
      logic [4:0] widths [4];
      n     = $urandom_range(1, 4);
      lead  = $urandom_range(0, 15);
      total = lead;
      for (int i = 0; i < n; i++) begin
         widths[i] = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 25));
         total += widths[i];
      end
      post(OP_REWIND, rand_val(), 5'($urandom), rand_addr());
      post(OP_READ, rand_val(), 5'(lead), rand_addr());
      for (int b = 0; b <= total / 8; b++)
         post(OP_LOAD, {17'($urandom), 8'h00}, 5'($urandom), 12'(b));
      for (int i = 0; i < n; i++)
         post(OP_WRITE, rand_val(), widths[i], rand_addr());
      post(OP_REWIND, rand_val(), 5'($urandom), rand_addr());
      post(OP_READ, rand_val(), 5'(lead), rand_addr());
      for (int i = 0; i < n; i++)
         post(OP_READ, rand_val(), widths[i], rand_addr());
   endtask

   // Any opcode with any fields; keep clears rare, each one sweeps the whole store
   task automatic post_noise();
      logic [2:0] op;
      op = 3'($urandom_range(0, 7));
      if (op == OP_CLEAR && $urandom_range(0, 9) != 0)
         op = OP_REWIND;
      post(op, rand_val(), 5'($urandom), rand_addr());
   endtask

   task automatic run_random(input int target);
      int start;
      int pick;
      start = posted;
      while (posted - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            post_round_trip();
         end else if (pick < 85) begin
            post_noise();
         end else begin
            // continue the stream from the cursor; walks into the size limit
            post($urandom_range(0, 1) ? OP_WRITE : OP_READ, rand_val(),
                 5'($urandom_range(0, 25)), rand_addr());
         end
      end
   endtask

   // Hold until every command is driven and every response has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (cmd_q.size() != 0 || req_valid || answer_q.size() != 0);
   endtask

   task automatic set_size(input logic [12:0] value);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      size_reg     = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      foreach (store_img[i]) store_img[i] = 8'h00;
      byte_pos = 0;
      bit_pos  = 0;
      size_reg = SIZE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      post_directed();
      foreach (SIZE_PLAN[i]) begin
         // every phase boundary drains the block, so the size write lands while idle
         set_size(SIZE_PLAN[i]);
         calm = (i == CALM_PHASE);
         run_random(PHASE_ITEMS);
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Drove %0d commands over %0d store sizes; checked %0d responses, %0d refused.",
               sent, $size(SIZE_PLAN) + 1, checked, refused);
      $display("Mismatches or stray responses: %0d", errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Driver: predict each accepted beat, then advance to the next command or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            answer_q.push_back(run_command(req_data));
            sent++;
         end
         // a pending beat holds its payload until it is taken
         if (!req_valid || !req_stall) begin
            if (cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= cmd_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check every response beat against the oldest prediction, stall at
   // random, and watch for a hang.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_q.size() == 0) begin
            errors++;
            $display("%0t: response beat with none expected: read_value=%h ok=%b",
                     $time, rsp_data.read_value, rsp_data.ok);
         end else begin
            want = answer_q.pop_front();
            checked++;
            if (!want.ok)
               refused++;
            if (rsp_data.read_value !== want.read_value) begin
               errors++;
               $display("%0t: read_value expected %h actual %h",
                        $time, want.read_value, rsp_data.read_value);
            end
            if (rsp_data.ok !== want.ok) begin
               errors++;
               $display("%0t: ok expected %b actual %b", $time, want.ok, rsp_data.ok);
            end
         end
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      // count cycles in which no beat moves on either channel
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet = 0;
      else
         quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, quiet);
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
